// ===== sv/fba_pkg.sv =====
// fba_pkg: shared types, codes and defaults of the fit block allocator
// no dependencies; imported by every module of the block but fba_ram

package fba_pkg;

  // default sizing of the capacity store
  localparam int DEF_NUM_BLOCKS = 64;
  localparam int DEF_SIZE_BITS  = 16;

  // fixed widths of the stream fields
  localparam int IDX_FIELD_W = 6;
  localparam int AMT_FIELD_W = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // configuration register widths and reset values
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [MODE_W-1:0]  FIT_MODE_RST    = 2'd0;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 7'd64;

  // register indexes, taken from paddr word address
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // placement policies
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // configuration seen by the engine
  typedef struct packed {
    logic [MODE_W-1:0]  fit_mode;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

  // engine sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

endpackage

// ===== sv/fba_ram.sv =====
// fba_ram: generic single-write, single-read synchronous ram
// registered read, data in the cycle after re; no dependencies

module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fba_cfg.sv =====
// fba_cfg: apb-style register file holding fit mode and block count
// depends on fba_pkg

module fba_cfg import fba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [MODE_W-1:0]  fit_mode_r, fit_mode_nxt;
  logic [COUNT_W-1:0] block_count_r, block_count_nxt;
  logic               wr_en;
  logic               reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  // register write decode
  always_comb begin
    fit_mode_nxt    = fit_mode_r;
    block_count_nxt = block_count_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_FIT_MODE:    fit_mode_nxt    = cfg_pwdata[MODE_W-1:0];
        REG_BLOCK_COUNT: block_count_nxt = cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= FIT_MODE_RST;
      block_count_r <= BLOCK_COUNT_RST;
    end else begin
      fit_mode_r    <= fit_mode_nxt;
      block_count_r <= block_count_nxt;
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_FIT_MODE:    cfg_prdata = CFG_DATA_W'(fit_mode_r);
      REG_BLOCK_COUNT: cfg_prdata = CFG_DATA_W'(block_count_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.fit_mode    = fit_mode_r;
  assign cfg.block_count = block_count_r;

endmodule

// ===== sv/fba_engine.sv =====
// fba_engine: sequencer that loads capacities and scans the capacity ram
// for a fitting block; depends on fba_pkg, drives the fba_ram ports

module fba_engine import fba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS,
  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  // capacity ram
  output logic                   ram_we,
  output logic [IDX_W-1:0]       ram_waddr,
  output logic [SIZE_BITS-1:0]   ram_wdata,
  output logic                   ram_re,
  output logic [IDX_W-1:0]       ram_raddr,
  input  logic [SIZE_BITS-1:0]   ram_rdata
);

  localparam int CMP_W = (SIZE_BITS > AMT_FIELD_W) ? SIZE_BITS : AMT_FIELD_W;
  localparam int IW2   = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  state_t st_r, st_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;

  // pending result
  logic                   res_grant_r, res_grant_nxt;
  logic [IDX_FIELD_W-1:0] res_block_r, res_block_nxt;
  logic [AMT_FIELD_W-1:0] res_left_r, res_left_nxt;

  // scan state
  logic [CMP_W-1:0] req_r, req_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] last_r, last_nxt;
  logic             issue_done_r, issue_done_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [CMP_W-1:0] best_cap_r, best_cap_nxt;

  // request fields
  logic                   in_op;
  logic [IDX_FIELD_W-1:0] in_idx;
  logic [AMT_FIELD_W-1:0] in_amt;
  logic                   in_acc;

  // derived values
  logic [31:0]          eff32;
  logic [CNT_W-1:0]     eff;
  logic [IW2-1:0]       in_idx_ext;
  logic                 in_range;
  logic [CMP_W-1:0]     amt_ext;
  logic [SIZE_BITS-1:0] ld_val;
  logic [CMP_W-1:0]     ld_left_ext;
  logic [CMP_W-1:0]     cap_ext;
  logic                 fits;
  logic [CMP_W-1:0]     diff;
  logic [CMP_W-1:0]     left_ext;
  logic [IW2-1:0]       best_ext;
  logic                 out_free;

  assign in_op  = in_tuser;
  assign in_idx = in_tdata[IDX_FIELD_W-1:0];
  assign in_amt = in_tdata[IDX_FIELD_W +: AMT_FIELD_W];

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  // effective block count, clipped to the store
  assign eff32 = (32'(cfg.block_count) < 32'(NUM_BLOCKS)) ?
                 32'(cfg.block_count) : 32'(NUM_BLOCKS);
  assign eff   = eff32[CNT_W-1:0];

  assign in_idx_ext  = IW2'(in_idx);
  assign in_range    = 32'(in_idx) < 32'(NUM_BLOCKS);
  assign amt_ext     = CMP_W'(in_amt);
  assign ld_val      = amt_ext[SIZE_BITS-1:0];
  assign ld_left_ext = CMP_W'(ld_val);

  assign cap_ext  = CMP_W'(ram_rdata);
  assign fits     = req_r <= cap_ext;
  assign diff     = best_cap_r - req_r;
  assign left_ext = CMP_W'(diff[SIZE_BITS-1:0]);
  assign best_ext = IW2'(best_idx_r);

  // read port issues one address per scan cycle
  assign ram_re    = (st_r == S_SCAN) & ~issue_done_r;
  assign ram_raddr = cnt_r[IDX_W-1:0];

  // write port: load on accept, write-back on commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_r;
    ram_wdata = diff[SIZE_BITS-1:0];
    if (in_acc && in_op == OP_LOAD) begin
      ram_we    = in_range;
      ram_waddr = in_idx_ext[IDX_W-1:0];
      ram_wdata = ld_val;
    end else if (st_r == S_COMMIT) begin
      ram_we = found_r;
    end
  end

  // sequencer
  always_comb begin
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    res_grant_nxt  = res_grant_r;
    res_block_nxt  = res_block_r;
    res_left_nxt   = res_left_r;
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    issue_done_nxt = issue_done_r;
    rd_vld_nxt     = ram_re;
    rd_last_nxt    = ram_re & (cnt_r == last_r);
    rd_idx_nxt     = cnt_r[IDX_W-1:0];
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_cap_nxt   = best_cap_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // compare a returned capacity against the current pick
    if (rd_vld_r && fits) begin
      priority if (!found_r) begin
        found_nxt    = 1'b1;
        best_idx_nxt = rd_idx_r;
        best_cap_nxt = cap_ext;
      end else if (cfg.fit_mode == FIT_BEST && cap_ext < best_cap_r) begin
        best_idx_nxt = rd_idx_r;
        best_cap_nxt = cap_ext;
      end else if (cfg.fit_mode == FIT_WORST && cap_ext > best_cap_r) begin
        best_idx_nxt = rd_idx_r;
        best_cap_nxt = cap_ext;
      end else begin
      end
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_LOAD) begin
            res_grant_nxt = 1'b0;
            res_block_nxt = in_idx;
            res_left_nxt  = in_range ? ld_left_ext[AMT_FIELD_W-1:0] : '0;
            st_nxt        = S_RESULT;
          end else begin
            req_nxt        = amt_ext;
            found_nxt      = 1'b0;
            cnt_nxt        = '0;
            last_nxt       = eff - CNT_W'(1);
            issue_done_nxt = 1'b0;
            st_nxt         = (eff == '0) ? S_COMMIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == last_r) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (rd_vld_r && rd_last_r) begin
          st_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        res_grant_nxt = found_r;
        res_block_nxt = found_r ? best_ext[IDX_FIELD_W-1:0] : '0;
        res_left_nxt  = found_r ? left_ext[AMT_FIELD_W-1:0] : '0;
        st_nxt        = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_grant_r;
          out_data_nxt  = {2'b00, res_left_r, res_block_r};
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_valid_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      issue_done_r <= 1'b1;
      found_r      <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_last_r    <= rd_last_nxt;
      issue_done_r <= issue_done_nxt;
      found_r      <= found_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    res_grant_r <= res_grant_nxt;
    res_block_r <= res_block_nxt;
    res_left_r  <= res_left_nxt;
    req_r       <= req_nxt;
    cnt_r       <= cnt_nxt;
    last_r      <= last_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cap_r  <= best_cap_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/fit_block_allocator.sv =====
// fit_block_allocator: first, best and worst fit block allocator, top level
// depends on fba_pkg, fba_ram, fba_cfg and fba_engine
//
//   channel  dir  handshake              contents
//   in_      in   in_tvalid/in_tready    tdata block_index, amount; tuser opcode
//   out_     out  out_tvalid/out_tready  tdata chosen_block, left_after; tuser granted
//   cfg_     in   apb psel/penable       fit_mode @0x0, block_count @0x4
//
// a load goes straight to the result state; an allocate scans min(block_count,
// NUM_BLOCKS) blocks through the single read port of the capacity ram, which is
// read once per block in use, then commits the write-back before the result.
// one request is in flight at a time; the next is taken while a result waits.
// reset clears control state only; the ram holds garbage until blocks are loaded.
// a stalled result holds in the output register until out_tready.

module fit_block_allocator import fba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [5:0] block_index, [21:6] amount
  input  logic                   in_tuser,   // [0] opcode
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [5:0] chosen_block, [21:6] left_after
  output logic                   out_tuser,  // [0] granted
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  cfg_t                 cfg;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;

  // configuration registers
  fba_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // free capacity store
  fba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_cap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // load and scan sequencer
  fba_engine #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

endmodule

// ===== tb/fit_block_allocator_tb.sv =====
// fit_block_allocator_tb: self-checking testbench of the first, best and worst fit allocator
// drives requests and register writes, predicts each result in its own shadow of the store
// depends on fba_pkg and fit_block_allocator

`timescale 1ns / 1ps

module fit_block_allocator_tb;
  import fba_pkg::*;

  localparam int NUM_BLK     = DEF_NUM_BLOCKS;
  localparam int LIMIT       = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  // fit_mode value that has no policy of its own
  localparam logic [MODE_W-1:0] FIT_UNDEF = 2'd3;

  // byte addresses of the two registers
  localparam logic [CFG_ADDR_W-1:0] ADDR_FIT_MODE    = {REG_FIT_MODE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_BLOCK_COUNT = {REG_BLOCK_COUNT, 2'b00};

  typedef struct packed {
    logic                   op;
    logic [IDX_FIELD_W-1:0] idx;
    logic [AMT_FIELD_W-1:0] amt;
  } alloc_req_t;

  typedef struct packed {
    logic                   granted;
    logic [IDX_FIELD_W-1:0] blk;
    logic [AMT_FIELD_W-1:0] left;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [5:0] block_index, [21:6] amount
  logic                   in_tuser = 1'b0; // [0] opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [5:0] chosen_block, [21:6] left_after
  logic                   out_tuser;       // [0] granted
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // shadow of the block: capacities and configuration
  logic [AMT_FIELD_W-1:0] cap_shadow [NUM_BLK];
  logic [MODE_W-1:0]      cfg_mode  = FIT_MODE_RST;
  logic [COUNT_W-1:0]     cfg_count = BLOCK_COUNT_RST;
  logic [NUM_BLK-1:0]     loaded_map = '0;

  alloc_req_t    pending_requests [$];
  alloc_result_t expected_results [$];
  alloc_req_t    req_on_bus;

  int  mismatches = 0;
  int  cycle_cnt = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  hold_left = 0;
  int  hold_asks = 0;
  int  hold_seen = 0;
  bit  quiet_tail = 1'b0;

  fit_block_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("fit_block_allocator regression: fail");
      $finish;
    end
  end

  function automatic int blocks_in_use();
    return (cfg_count > NUM_BLK) ? NUM_BLK : int'(cfg_count);
  endfunction

  // applies one request to the shadow store and returns its result
  function automatic alloc_result_t apply_request(alloc_req_t r);
    alloc_result_t res;
    int  n;
    int  pick;
    bit  found;
    bit  stop;
    res   = '0;
    found = 1'b0;
    stop  = 1'b0;
    pick  = 0;
    if (r.op == OP_LOAD) begin
      cap_shadow[r.idx] = r.amt;
      res.blk  = r.idx;
      res.left = r.amt;
    end else begin
      n = blocks_in_use();
      for (int j = 0; j < n && !stop; j++) begin
        if (r.amt <= cap_shadow[j]) begin
          if (!found) begin
            found = 1'b1;
            pick  = j;
            // only best and worst fit look past the first fitting block
            if (cfg_mode != FIT_BEST && cfg_mode != FIT_WORST) stop = 1'b1;
          end else if (cfg_mode == FIT_BEST && cap_shadow[j] < cap_shadow[pick]) begin
            pick = j;
          end else if (cfg_mode == FIT_WORST && cap_shadow[j] > cap_shadow[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        cap_shadow[pick] = cap_shadow[pick] - r.amt;
        res.granted = 1'b1;
        res.blk     = pick[IDX_FIELD_W-1:0];
        res.left    = cap_shadow[pick];
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(apply_request(req_on_bus));
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req_on_bus = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= req_on_bus.op;
          in_tdata  <= {2'b00, req_on_bus.amt, req_on_bus.idx};
          if (!quiet_tail && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 12);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready control
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.granted = out_tuser;
        got.blk     = out_tdata[IDX_FIELD_W-1:0];
        got.left    = out_tdata[IDX_FIELD_W +: AMT_FIELD_W];
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with none waiting: granted %0d block %0d left %0d",
                               got.granted, got.blk, got.left));
        end else begin
          want = expected_results.pop_front();
          if (got.granted !== want.granted || got.blk !== want.blk || got.left !== want.left)
            flag_error($sformatf("expected granted %0d block %0d left %0d, got %0d %0d %0d",
                                 want.granted, want.blk, want.left,
                                 got.granted, got.blk, got.left));
        end
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic op, input int idx, input int amt);
    alloc_req_t r;
    r.op  = op;
    r.idx = idx[IDX_FIELD_W-1:0];
    r.amt = amt[AMT_FIELD_W-1:0];
    if (op == OP_LOAD) loaded_map[r.idx] = 1'b1;
    pending_requests.push_back(r);
  endtask

  function automatic int pick_load_amount();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 0;
    if (roll < 20) return 16'hffff;
    if (roll < 60) return $urandom_range(0, 16'hffff);
    return $urandom_range(0, 4095);
  endfunction

  // mostly well-formed traffic: fill unloaded blocks in use, then allocate
  task automatic queue_random_req();
    int n;
    int roll;
    int j;
    int hole;
    n    = blocks_in_use();
    hole = -1;
    for (j = 0; j < n; j++)
      if (!loaded_map[j] && hole < 0) hole = j;
    roll = $urandom_range(0, 99);
    if (hole >= 0) begin
      queue_req(OP_LOAD, hole, pick_load_amount());
    end else if (roll >= 90 || (roll >= 55 && n == 0)) begin
      queue_req(OP_LOAD, $urandom_range(0, NUM_BLK - 1), pick_load_amount());
    end else if (roll >= 55) begin
      queue_req(OP_LOAD, $urandom_range(0, n - 1), pick_load_amount());
    end else begin
      // allocate sizes lean on current capacities so grants are common
      j    = (n > 0) ? $urandom_range(0, n - 1) : 0;
      roll = $urandom_range(0, 99);
      if (roll < 25 || n == 0)
        queue_req(OP_ALLOC, $urandom_range(0, 63), $urandom_range(0, 255));
      else if (roll < 50)
        queue_req(OP_ALLOC, $urandom_range(0, 63), cap_shadow[j]);
      else if (roll < 60)
        queue_req(OP_ALLOC, $urandom_range(0, 63), 0);
      else if (roll < 70)
        queue_req(OP_ALLOC, $urandom_range(0, 63), 16'hffff);
      else if (roll < 85)
        queue_req(OP_ALLOC, $urandom_range(0, 63), $urandom_range(0, 16'hffff));
      else
        queue_req(OP_ALLOC, $urandom_range(0, 63), cap_shadow[j] + 1);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (!wr && cfg_prdata !== data)
      flag_error($sformatf("register 0x%0h read %0h, expected %0h", addr, cfg_prdata, data));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // writes both registers while idle and reads them back
  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
    apb_access(1'b1, ADDR_BLOCK_COUNT, CFG_DATA_W'(count));
    cfg_count = count;
    apb_access(1'b1, ADDR_FIT_MODE, CFG_DATA_W'(mode));
    cfg_mode = mode;
    apb_access(1'b0, ADDR_BLOCK_COUNT, CFG_DATA_W'(count));
    apb_access(1'b0, ADDR_FIT_MODE, CFG_DATA_W'(mode));
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [MODE_W-1:0] mode_plan [8];
    int count_plan [8];
    int item_plan [8];
    int p;
    int k;
    mode_plan  = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNDEF,
                   FIT_BEST, FIT_FIRST, FIT_WORST, FIT_FIRST};
    count_plan = '{1, 64, 127, 64, -1, 65, 16, 64};
    item_plan  = '{40, 100, 60, 60, 60, 60, 60, 60};

    // a load still queued leaves its shadow entry stale; it only steers request sizes
    foreach (cap_shadow[i]) cap_shadow[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // first fit over four blocks: extremes, zero-size request, load above count
    set_config(FIT_FIRST, 7'd4);
    queue_req(OP_LOAD, 0, 0);
    queue_req(OP_LOAD, 1, 16'hffff);
    queue_req(OP_LOAD, 2, 100);
    queue_req(OP_LOAD, 3, 100);
    queue_req(OP_LOAD, 63, 16'h5a5a);
    queue_req(OP_ALLOC, 63, 0);
    queue_req(OP_ALLOC, 0, 16'hffff);
    queue_req(OP_ALLOC, 21, 16'hffff);
    queue_req(OP_ALLOC, 42, 50);
    wait_idle();

    // best fit, including a tie between two empty blocks
    set_config(FIT_BEST, 7'd4);
    queue_req(OP_LOAD, 0, 60);
    queue_req(OP_ALLOC, 0, 40);
    queue_req(OP_ALLOC, 0, 10);
    queue_req(OP_ALLOC, 0, 0);
    wait_idle();

    // worst fit with equal capacities, then a request too large
    set_config(FIT_WORST, 7'd4);
    queue_req(OP_LOAD, 0, 100);
    queue_req(OP_ALLOC, 0, 30);
    queue_req(OP_ALLOC, 0, 30);
    queue_req(OP_ALLOC, 0, 71);
    wait_idle();

    // undefined mode with no blocks in use: every allocate fails
    set_config(FIT_UNDEF, 7'd0);
    queue_req(OP_ALLOC, 0, 0);
    queue_req(OP_ALLOC, 0, 5);
    queue_req(OP_LOAD, 62, 16'h8001);
    wait_idle();

    // random phases over a spread of settings
    for (p = 0; p < 8; p++) begin
      set_config(mode_plan[p],
                 (count_plan[p] < 0) ? COUNT_W'($urandom_range(2, 16)) : COUNT_W'(count_plan[p]));
      if (p == 7) quiet_tail = 1'b1;
      // long receiver stall so the block backs up into its input
      if (p == 2) hold_asks++;
      for (k = 0; k < item_plan[p]; k++) begin
        while (pending_requests.size() > 3) @(negedge clk);
        queue_random_req();
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fit_block_allocator regression: pass");
    end else begin
      if (expected_results.size() != 0)
        $display("%0d results never arrived", expected_results.size());
      $display("fit_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
